/* rtl/core/cmm_pkg.sv */
// Shared types and constants of the confusion matrix metrics block.
`default_nettype none

package cmm_pkg;

  // Fraction bits of every metric and the widths that follow from them.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q_W       = FRAC_BITS + 1;
  localparam int unsigned MCC_W     = FRAC_BITS + 2;
  localparam int unsigned CNT_OUT_W = 32;
  localparam int unsigned FLAG_W    = 5;

  // Positions in the undefined flags field.
  localparam int unsigned FLAG_SENS = 0;
  localparam int unsigned FLAG_SPEC = 1;
  localparam int unsigned FLAG_ACC  = 2;
  localparam int unsigned FLAG_F1   = 3;
  localparam int unsigned FLAG_MCC  = 4;

  localparam int unsigned IN_W  = 8;
  localparam int unsigned OUT_W = 224;

  // One input item, last field in the lowest bit.
  typedef struct packed {
    logic [2:0] pad;
    logic       report;
    logic       clear_first;
    logic       count_enable;
    logic       observed;
    logic       predicted;
  } item_t;

  // One result item, last field in the lowest bits.
  typedef struct packed {
    logic [4:0]                pad;
    logic [FLAG_W-1:0]         undefined_flags;
    logic signed [MCC_W-1:0]   matthews;
    logic [Q_W-1:0]            f_one;
    logic [Q_W-1:0]            accuracy;
    logic [Q_W-1:0]            specificity;
    logic [Q_W-1:0]            sensitivity;
    logic [CNT_OUT_W-1:0]      false_neg;
    logic [CNT_OUT_W-1:0]      false_pos;
    logic [CNT_OUT_W-1:0]      true_neg;
    logic [CNT_OUT_W-1:0]      true_pos;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/cmm_front.sv */
// Front end: takes sample items, keeps the four saturating counters, queues report snapshots.
`default_nettype none

module cmm_front #(
  parameter int unsigned CW = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  input  wire cmm_pkg::item_t    item_i,
  output logic                   push_valid_o,
  input  wire logic              push_ready_i,
  output logic [4*CW-1:0]        push_data_o
);

  localparam logic [CW-1:0] CntMax = {CW{1'b1}};

  logic [CW-1:0] tp_q, tn_q, fp_q, fn_q;
  logic [CW-1:0] tp_d, tn_d, fp_d, fn_d;
  logic [CW-1:0] tp_b, tn_b, fp_b, fn_b;
  logic          take;

  assign item_ready_o = push_ready_i;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    tp_b = item_i.clear_first ? '0 : tp_q;
    tn_b = item_i.clear_first ? '0 : tn_q;
    fp_b = item_i.clear_first ? '0 : fp_q;
    fn_b = item_i.clear_first ? '0 : fn_q;
    tp_d = tp_b;
    tn_d = tn_b;
    fp_d = fp_b;
    fn_d = fn_b;
    if (item_i.count_enable) begin
      if (item_i.predicted && item_i.observed) begin
        tp_d = (tp_b == CntMax) ? tp_b : tp_b + CW'(1);
      end else if (!item_i.predicted && !item_i.observed) begin
        tn_d = (tn_b == CntMax) ? tn_b : tn_b + CW'(1);
      end else if (item_i.predicted) begin
        fp_d = (fp_b == CntMax) ? fp_b : fp_b + CW'(1);
      end else begin
        fn_d = (fn_b == CntMax) ? fn_b : fn_b + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q <= '0;
      tn_q <= '0;
      fp_q <= '0;
      fn_q <= '0;
    end else if (take) begin
      tp_q <= tp_d;
      tn_q <= tn_d;
      fp_q <= fp_d;
      fn_q <= fn_d;
    end
  end

  assign push_valid_o = take && item_i.report;
  assign push_data_o  = {fn_d, fp_d, tn_d, tp_d};

endmodule

`default_nettype wire

/* rtl/core/cmm_queue.sv */
// Two-entry queue of counter snapshots between the front and back ends.
`default_nettype none

module cmm_queue #(
  parameter int unsigned WIDTH = 128
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WIDTH-1:0]      out_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_data_i;
  end

endmodule

`default_nettype wire

/* rtl/core/cmm_back.sv */
// Back end: dividers, shift-add multiplier and root search that turn a snapshot into a report.
`default_nettype none

module cmm_back #(
  parameter int unsigned CW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            snap_valid_i,
  output logic                 snap_ready_o,
  input  wire logic [4*CW-1:0] snap_data_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output cmm_pkg::result_t     res_data_o
);

  localparam int unsigned FB  = cmm_pkg::FRAC_BITS;
  localparam int unsigned QW  = cmm_pkg::Q_W;
  localparam int unsigned MW2 = cmm_pkg::MCC_W;
  localparam int unsigned BW  = 4 * CW + 2 * FB + 8;
  localparam int unsigned MW  = 2 * CW + 2;
  localparam int unsigned DW  = CW + 3;
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned MCW = $clog2(MW);
  localparam int unsigned KW  = $clog2(FB + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_P1   = 4'd1;
  localparam logic [3:0] ST_P2   = 4'd2;
  localparam logic [3:0] ST_RR   = 4'd3;
  localparam logic [3:0] ST_D12  = 4'd4;
  localparam logic [3:0] ST_D34  = 4'd5;
  localparam logic [3:0] ST_DD   = 4'd6;
  localparam logic [3:0] ST_SQA  = 4'd7;
  localparam logic [3:0] ST_SQB  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] tp_in, tn_in, fp_in, fn_in;
  logic [CW-1:0] tp_s, tn_s, fp_s, fn_s;
  logic          take, mul_last;

  // Shift-add multiplier.
  logic [BW-1:0]  ma_q, acc_q, acc_step;
  logic [MW-1:0]  mb_q;
  logic [MCW-1:0] mcnt_q;

  // Matthews working values.
  logic [2*CW-1:0] p1_q, p2_w, n_w;
  logic            neg_q, neg_w;
  logic [MW-1:0]   d12_q;
  logic [BW-1:0]   r_q, d_q, s_q, t_q, cand_q, sq_c2;
  logic            sq_ok;
  logic [QW-1:0]   qr_q, q_fin;
  logic [KW-1:0]   k_q;

  // Four restoring dividers.
  logic [DW-1:0] dden_q [4];
  logic [DW-1:0] drem_q [4];
  logic [QW-1:0] dquo_q [4];
  logic [DW-1:0] dshift [4];
  logic          dge    [4];
  logic [KW-1:0] dstep_q;
  logic          div_busy_q;

  logic [cmm_pkg::FLAG_W-1:0] flg_q;
  logic [MW2-1:0]             mcc_w;
  cmm_pkg::result_t           res_q;

  assign tp_in = snap_data_i[CW-1:0];
  assign tn_in = snap_data_i[2*CW-1:CW];
  assign fp_in = snap_data_i[3*CW-1:2*CW];
  assign fn_in = snap_data_i[4*CW-1:3*CW];

  assign snap_ready_o = (state_q == ST_IDLE);
  assign take         = snap_valid_i && snap_ready_o;
  assign res_valid_o  = (state_q == ST_OUT);
  assign res_data_o   = res_q;

  assign acc_step = acc_q + (mb_q[0] ? ma_q : '0);
  assign mul_last = (mcnt_q == MCW'(MW - 1));

  assign p2_w  = acc_step[2*CW-1:0];
  assign neg_w = (p1_q < p2_w);
  assign n_w   = neg_w ? (p2_w - p1_q) : (p1_q - p2_w);

  assign sq_c2 = cand_q + (d_q << (2 * k_q));
  assign sq_ok = (sq_c2 <= r_q);
  assign q_fin = qr_q | QW'(sq_ok);
  assign mcc_w = flg_q[cmm_pkg::FLAG_MCC] ? '0 :
                 (neg_q ? (MW2'(0) - MW2'(q_fin)) : MW2'(q_fin));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dshift[i] = (dstep_q == KW'(0)) ? drem_q[i] : (drem_q[i] << 1);
      dge[i]    = (dshift[i] >= dden_q[i]);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (snap_valid_i) state_d = ST_P1;
      ST_P1:   if (mul_last) state_d = ST_P2;
      ST_P2:   if (mul_last) state_d = ST_RR;
      ST_RR:   if (mul_last) state_d = ST_D12;
      ST_D12:  if (mul_last) state_d = ST_D34;
      ST_D34:  if (mul_last) state_d = ST_DD;
      ST_DD:   if (mul_last) state_d = ST_SQA;
      ST_SQA:  state_d = ST_SQB;
      ST_SQB:  state_d = (k_q == KW'(0)) ? ST_OUT : ST_SQA;
      ST_OUT:  if (res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      div_busy_q <= 1'b0;
      dstep_q    <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        div_busy_q <= 1'b1;
        dstep_q    <= '0;
      end else if (div_busy_q) begin
        dstep_q <= dstep_q + KW'(1);
        if (dstep_q == KW'(FB)) div_busy_q <= 1'b0;
      end
    end
  end

  // Dividers: numerator times 2^FB over denominator, one quotient bit a cycle.
  always_ff @(posedge clk_i) begin
    if (take) begin
      drem_q[0] <= DW'(tp_in);
      dden_q[0] <= DW'(tp_in) + DW'(fn_in);
      drem_q[1] <= DW'(tn_in);
      dden_q[1] <= DW'(tn_in) + DW'(fp_in);
      drem_q[2] <= DW'(tp_in) + DW'(tn_in);
      dden_q[2] <= DW'(tp_in) + DW'(tn_in) + DW'(fp_in) + DW'(fn_in);
      drem_q[3] <= DW'(tp_in) << 1;
      dden_q[3] <= (DW'(tp_in) << 1) + DW'(fp_in) + DW'(fn_in);
    end else if (div_busy_q) begin
      for (int i = 0; i < 4; i++) begin
        drem_q[i] <= dge[i] ? (dshift[i] - dden_q[i]) : dshift[i];
        dquo_q[i] <= {dquo_q[i][QW-2:0], dge[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (snap_valid_i) begin
          tp_s   <= tp_in;
          tn_s   <= tn_in;
          fp_s   <= fp_in;
          fn_s   <= fn_in;
          ma_q   <= BW'(tp_in);
          mb_q   <= MW'(tn_in);
          acc_q  <= '0;
          mcnt_q <= '0;
          flg_q[cmm_pkg::FLAG_SENS] <= (DW'(tp_in) + DW'(fn_in)) == '0;
          flg_q[cmm_pkg::FLAG_SPEC] <= (DW'(tn_in) + DW'(fp_in)) == '0;
          flg_q[cmm_pkg::FLAG_ACC]  <=
            (DW'(tp_in) + DW'(tn_in) + DW'(fp_in) + DW'(fn_in)) == '0;
          flg_q[cmm_pkg::FLAG_F1]   <=
            ((DW'(tp_in) << 1) + DW'(fp_in) + DW'(fn_in)) == '0;
          flg_q[cmm_pkg::FLAG_MCC]  <=
            ((SW'(tp_in) + SW'(fp_in)) == '0) || ((SW'(tp_in) + SW'(fn_in)) == '0) ||
            ((SW'(tn_in) + SW'(fp_in)) == '0) || ((SW'(tn_in) + SW'(fn_in)) == '0);
        end
      end
      ST_P1, ST_P2, ST_RR, ST_D12, ST_D34, ST_DD: begin
        ma_q   <= ma_q << 1;
        mb_q   <= mb_q >> 1;
        acc_q  <= acc_step;
        mcnt_q <= mcnt_q + MCW'(1);
        if (mul_last) begin
          acc_q  <= '0;
          mcnt_q <= '0;
          if (state_q == ST_P1) begin
            p1_q <= acc_step[2*CW-1:0];
            ma_q <= BW'(fp_s);
            mb_q <= MW'(fn_s);
          end else if (state_q == ST_P2) begin
            neg_q <= neg_w;
            ma_q  <= BW'(n_w);
            mb_q  <= MW'(n_w);
          end else if (state_q == ST_RR) begin
            r_q  <= acc_step << (2 * FB);
            ma_q <= BW'(SW'(tp_s) + SW'(fp_s));
            mb_q <= MW'(SW'(tp_s) + SW'(fn_s));
          end else if (state_q == ST_D12) begin
            d12_q <= acc_step[MW-1:0];
            ma_q  <= BW'(SW'(tn_s) + SW'(fp_s));
            mb_q  <= MW'(SW'(tn_s) + SW'(fn_s));
          end else if (state_q == ST_D34) begin
            ma_q <= BW'(d12_q);
            mb_q <= acc_step[MW-1:0];
          end else begin
            d_q  <= acc_step;
            s_q  <= '0;
            t_q  <= '0;
            qr_q <= '0;
            k_q  <= KW'(FB);
          end
        end
      end
      ST_SQA: begin
        cand_q <= s_q + (t_q << (k_q + 1));
      end
      ST_SQB: begin
        if (sq_ok) begin
          s_q       <= sq_c2;
          t_q       <= t_q + (d_q << k_q);
          qr_q[k_q] <= 1'b1;
        end
        k_q <= k_q - KW'(1);
        if (k_q == KW'(0)) begin
          res_q.pad             <= '0;
          res_q.true_pos        <= cmm_pkg::CNT_OUT_W'(tp_s);
          res_q.true_neg        <= cmm_pkg::CNT_OUT_W'(tn_s);
          res_q.false_pos       <= cmm_pkg::CNT_OUT_W'(fp_s);
          res_q.false_neg       <= cmm_pkg::CNT_OUT_W'(fn_s);
          res_q.sensitivity     <= flg_q[cmm_pkg::FLAG_SENS] ? '0 : dquo_q[0];
          res_q.specificity     <= flg_q[cmm_pkg::FLAG_SPEC] ? '0 : dquo_q[1];
          res_q.accuracy        <= flg_q[cmm_pkg::FLAG_ACC]  ? '0 : dquo_q[2];
          res_q.f_one           <= flg_q[cmm_pkg::FLAG_F1]   ? '0 : dquo_q[3];
          res_q.matthews        <= mcc_w;
          res_q.undefined_flags <= flg_q;
        end
      end
      ST_OUT: begin
        ma_q <= ma_q;
      end
      default: begin
        ma_q <= ma_q;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/confusion_matrix_metrics.sv */
// Top level of the binary confusion matrix tally with quality metrics.
// Usage:
// Sample items arrive on the s_axis channel; each transfer may clear the four counters,
// tally one predicted/observed pair into them (saturating at full scale) and ask for a
// report, in that order. Tallies are taken one per cycle while the queue has room.
// A report transfer places a snapshot of the updated counts in a two-entry queue. The back
// end takes one snapshot at a time and works out sensitivity, specificity, accuracy and F1
// with four restoring dividers (one quotient bit a cycle), and the Matthews coefficient with
// one shared shift-add multiplier (six products in turn) followed by a bit-by-bit root
// search with a candidate step and a compare step for each result bit.
// The back end takes no new snapshot until m_axis has taken its result.
// Sample items keep flowing while a report is being worked out, until the queue holds two
// waiting snapshots; the input then stalls until the back end takes one.
// The result stays in its output register while the receiver stalls m_axis.
// Reset clears the counters, the queue and the back end sequencer; no result is pending.
`default_nettype none

module confusion_matrix_metrics #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // predicted, observed, count_enable, clear_first, report, then zero padding
  input  wire logic [cmm_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // true_pos, true_neg, false_pos, false_neg, sensitivity, specificity, accuracy, f_one,
  // matthews, undefined_flags, then zero padding
  output logic [cmm_pkg::OUT_W-1:0]          m_axis_tdata
);

  logic                     push_valid, push_ready;
  logic [4*COUNT_WIDTH-1:0] push_data;
  logic                     snap_valid, snap_ready;
  logic [4*COUNT_WIDTH-1:0] snap_data;
  cmm_pkg::result_t         res;

  // Counter update and report snapshot.
  cmm_front #(
    .CW(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_ready_o (s_axis_tready),
    .item_i       (cmm_pkg::item_t'(s_axis_tdata)),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouples the one-per-cycle front from the long metric computation.
  cmm_queue #(
    .WIDTH(4 * COUNT_WIDTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_data_i   (push_data),
    .out_valid_o (snap_valid),
    .out_ready_i (snap_ready),
    .out_data_o  (snap_data)
  );

  // Metric computation and output register.
  cmm_back #(
    .CW(COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_data_i  (snap_data),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_o   (res)
  );

  assign m_axis_tdata = res;

  // A snapshot only leaves the queue when the back end has taken it.
  a_snap_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(snap_valid) |-> $past(snap_ready))
    else $error("snapshot dropped from queue");

  // A flagged metric reads as zero.
  a_sens_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.undefined_flags[cmm_pkg::FLAG_SENS]) |-> (res.sensitivity == '0))
    else $error("flagged sensitivity not zero");

  a_mcc_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.undefined_flags[cmm_pkg::FLAG_MCC]) |-> (res.matthews == '0))
    else $error("flagged Matthews coefficient not zero");

  // A fraction never exceeds one.
  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.accuracy <= cmm_pkg::Q_W'(1 << cmm_pkg::FRAC_BITS)))
    else $error("accuracy above one");

endmodule

`default_nettype wire
